// File: src/spi_response_header_checker_defines.svh
// Assertion macros for the SPI response header checker
`ifndef SPI_RESPONSE_HEADER_CHECKER_DEFINES_SVH
`define SPI_RESPONSE_HEADER_CHECKER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define SRHC_ASSERT_NOW(label, clk, rst_n, cond, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
    else $error("spi_rhc check failed");

// next-cycle implication, checked out of reset
`define SRHC_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
    else $error("spi_rhc check failed");

`endif

// File: src/spi_rhc_pkg.sv
// Types, constants and CRC function shared by the SPI response header checker
package spi_rhc_pkg;

  localparam int unsigned PosW = 11;
  localparam int unsigned WinW = 10;

  localparam logic [PosW-1:0] SKIP_BYTES = 11'd6;
  localparam logic [WinW-1:0] SCAN_RESET = 10'd400;
  localparam logic [7:0]      READ_ACK   = 8'h82;
  localparam logic [7:0]      WRITE_ACK  = 8'h81;
  localparam logic [7:0]      CRC_POLY   = 8'h8c;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_SKIP,
    PH_SCAN,
    PH_HEADER,
    PH_PAYLOAD
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK,
    ST_NO_MARKER,
    ST_ADDR_MISMATCH,
    ST_COUNT_MISMATCH,
    ST_CRC_ERROR
  } status_t;

  typedef enum logic [2:0] {
    HDR_NONE,
    HDR_ADDR_LO,
    HDR_ADDR_HI,
    HDR_COUNT_LO,
    HDR_COUNT_HI,
    HDR_CRC
  } hdr_idx_t;

  typedef struct packed {
    logic [7:0]  rx_byte;
    logic        start_of_frame;
    logic        req_type;
    logic [15:0] expected_address;
    logic [15:0] expected_count;
  } in_item_t;

  typedef struct packed {
    logic       has_data;
    logic [7:0] data_byte;
    status_t    status;
    logic       last;
  } out_item_t;

  // handshake between the core and the output register
  typedef struct packed {
    logic push;
    logic free;
  } res_ctl_t;

  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    logic [7:0] d;
    logic       fb;
    c = crc;
    d = data;
    for (int k = 0; k < 8; k++) begin
      fb = c[0] ^ d[0];
      d  = d >> 1;
      c  = c >> 1;
      if (fb) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

endpackage

// File: src/spi_rhc_in_stage.sv
// Input register stage: holds one received transaction for the core
module spi_rhc_in_stage (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  spi_rhc_pkg::in_item_t in_item,
  input  logic                  advance,
  output logic                  st_valid,
  output spi_rhc_pkg::in_item_t st_item
);
  import spi_rhc_pkg::*;

  logic     valid_r;
  logic     valid_nxt;
  in_item_t item_r;

  assign in_ready = !valid_r || advance;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign st_valid = valid_r;
  assign st_item  = item_r;

endmodule

// File: src/spi_rhc_core.sv
// Frame tracker: skip, marker scan, header compare with CRC-8, payload count
module spi_rhc_core (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_wr_en,
  input  logic [9:0]               cfg_wr_data,
  input  logic                     st_valid,
  input  spi_rhc_pkg::in_item_t    st_item,
  input  spi_rhc_pkg::res_ctl_t    res_ctl_in,
  output logic                     advance,
  output logic                     push,
  output spi_rhc_pkg::out_item_t   res_item
);
  import spi_rhc_pkg::*;

  logic [WinW-1:0] scan_window_r;
  phase_t          phase_r,  phase_nxt;
  logic [PosW-1:0] pos_r,    pos_nxt;
  hdr_idx_t        hidx_r,   hidx_nxt;
  logic            dir_r,    dir_nxt;
  logic [15:0]     addr_r,   addr_nxt;
  logic [15:0]     cnt_r,    cnt_nxt;
  logic [7:0]      crc_r,    crc_nxt;
  status_t         mis_r,    mis_nxt;
  logic [15:0]     rem_r,    rem_nxt;
  logic            res_valid;

  always_comb begin
    logic [7:0]      b;
    logic [7:0]      marker;
    logic [7:0]      expect_b;
    logic [WinW-1:0] win;
    status_t         st;
    b         = st_item.rx_byte;
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    hidx_nxt  = hidx_r;
    dir_nxt   = dir_r;
    addr_nxt  = addr_r;
    cnt_nxt   = cnt_r;
    crc_nxt   = crc_r;
    mis_nxt   = mis_r;
    rem_nxt   = rem_r;
    res_valid = 1'b0;
    res_item  = '{has_data: 1'b0, data_byte: 8'h00, status: ST_OK, last: 1'b0};
    if (st_item.start_of_frame) begin
      dir_nxt   = st_item.req_type;
      addr_nxt  = st_item.expected_address;
      cnt_nxt   = st_item.expected_count;
      phase_nxt = PH_SKIP;
      pos_nxt   = '0;
      hidx_nxt  = HDR_NONE;
      crc_nxt   = 8'h00;
      mis_nxt   = ST_OK;
      rem_nxt   = 16'h0000;
    end
    marker   = dir_nxt ? WRITE_ACK : READ_ACK;
    win      = (scan_window_r == '0) ? WinW'(1) : scan_window_r;
    expect_b = 8'h00;
    st       = mis_nxt;
    case (phase_nxt)
      PH_SKIP: begin
        pos_nxt = pos_nxt + PosW'(1);
        if (pos_nxt >= SKIP_BYTES) begin
          phase_nxt = PH_SCAN;
          pos_nxt   = '0;
        end
      end
      PH_SCAN: begin
        if (b == marker) begin
          crc_nxt   = crc8_step(8'h00, b);
          hidx_nxt  = HDR_ADDR_LO;
          mis_nxt   = ST_OK;
          phase_nxt = PH_HEADER;
        end else begin
          pos_nxt = pos_nxt + PosW'(1);
          if (pos_nxt >= {1'b0, win}) begin
            phase_nxt = PH_IDLE;
            res_valid = 1'b1;
            res_item.status = ST_NO_MARKER;
            res_item.last   = 1'b1;
          end
        end
      end
      PH_HEADER: begin
        if (hidx_nxt != HDR_CRC) begin
          case (hidx_nxt)
            HDR_ADDR_LO:  expect_b = addr_nxt[7:0];
            HDR_ADDR_HI:  expect_b = addr_nxt[15:8];
            HDR_COUNT_LO: expect_b = cnt_nxt[7:0];
            default:      expect_b = cnt_nxt[15:8];
          endcase
          if (b != expect_b && mis_nxt == ST_OK) begin
            mis_nxt = (hidx_nxt == HDR_ADDR_LO || hidx_nxt == HDR_ADDR_HI) ?
                      ST_ADDR_MISMATCH : ST_COUNT_MISMATCH;
          end
          crc_nxt  = crc8_step(crc_nxt, b);
          hidx_nxt = hdr_idx_t'(hidx_nxt + 3'd1);
        end else begin
          hidx_nxt = HDR_NONE;
          if (st == ST_OK && b != crc_nxt) begin
            st = ST_CRC_ERROR;
          end
          if (st != ST_OK || dir_nxt || cnt_nxt == 16'h0000) begin
            phase_nxt = PH_IDLE;
            res_valid = 1'b1;
            res_item.status = st;
            res_item.last   = 1'b1;
          end else begin
            rem_nxt   = cnt_nxt;
            phase_nxt = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        rem_nxt            = rem_nxt - 16'd1;
        res_valid          = 1'b1;
        res_item.has_data  = 1'b1;
        res_item.data_byte = b;
        if (rem_nxt == 16'h0000) begin
          phase_nxt     = PH_IDLE;
          res_item.last = 1'b1;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
  end

  assign advance = st_valid && (!res_valid || res_ctl_in.free);
  assign push    = advance && res_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_window_r <= SCAN_RESET;
    end else if (cfg_wr_en) begin
      scan_window_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      pos_r   <= '0;
      hidx_r  <= HDR_NONE;
      dir_r   <= 1'b0;
      addr_r  <= 16'h0000;
      cnt_r   <= 16'h0000;
      crc_r   <= 8'h00;
      mis_r   <= ST_OK;
      rem_r   <= 16'h0000;
    end else if (advance) begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      hidx_r  <= hidx_nxt;
      dir_r   <= dir_nxt;
      addr_r  <= addr_nxt;
      cnt_r   <= cnt_nxt;
      crc_r   <= crc_nxt;
      mis_r   <= mis_nxt;
      rem_r   <= rem_nxt;
    end
  end

endmodule

// File: src/spi_rhc_out_reg.sv
// Result register: holds one result transaction until the sink takes it
module spi_rhc_out_reg (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  spi_rhc_pkg::out_item_t res_item,
  output spi_rhc_pkg::res_ctl_t  res_ctl_out,
  output logic                   out_valid,
  input  logic                   out_ready,
  output spi_rhc_pkg::out_item_t out_item
);
  import spi_rhc_pkg::*;

  logic      valid_r;
  logic      valid_nxt;
  out_item_t item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (push) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      item_r <= res_item;
    end
  end

  assign res_ctl_out.free = !valid_r || out_ready;
  assign res_ctl_out.push = push;
  assign out_valid        = valid_r;
  assign out_item         = item_r;

endmodule

// File: src/spi_response_header_checker.sv
// Top level of the SPI response header checker
//
//   port group  direction  handshake            payload
//   in_*        sink       in_valid/in_ready    in_item_t
//   out_*       source     out_valid/out_ready  out_item_t
//   cfg_*       sink       cfg_wr_en            scan_window, 10 bits
//
// One transaction per cycle sustained unless a full result register stalls it; a transaction
// passes the input register, the frame tracker logic and the result register.
// Reset: synchronous, active low; scan window returns to 400, frame tracker to idle.
// A full result register stalls only transactions that produce a result.
`include "spi_response_header_checker_defines.svh"

module spi_response_header_checker (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  spi_rhc_pkg::in_item_t  in_item,
  output logic                   out_valid,
  input  logic                   out_ready,
  output spi_rhc_pkg::out_item_t out_item,
  input  logic                   cfg_wr_en,
  input  logic [9:0]             cfg_wr_data
);
  import spi_rhc_pkg::*;

  logic      st_valid;
  in_item_t  st_item;
  logic      advance;
  logic      push;
  out_item_t res_item;
  res_ctl_t  res_ctl;

  spi_rhc_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .advance  (advance),
    .st_valid (st_valid),
    .st_item  (st_item)
  );

  spi_rhc_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .st_valid    (st_valid),
    .st_item     (st_item),
    .res_ctl_in  (res_ctl),
    .advance     (advance),
    .push        (push),
    .res_item    (res_item)
  );

  spi_rhc_out_reg u_out_reg (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .res_item    (res_item),
    .res_ctl_out (res_ctl),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_item    (out_item)
  );

  `SRHC_ASSERT_NOW(a_stall_only_when_full, clk, rst_n, st_valid && !advance, out_valid && !out_ready)
  `SRHC_ASSERT_NOW(a_push_into_free_slot, clk, rst_n, res_ctl.push, res_ctl.free)
  `SRHC_ASSERT_NOW(a_payload_status_ok, clk, rst_n, out_valid && out_item.has_data, out_item.status == ST_OK)
  `SRHC_ASSERT_NOW(a_status_is_last, clk, rst_n, out_valid && !out_item.has_data, out_item.last)

endmodule

// File: tb/tb.sv
// Self-checking testbench for the SPI response header checker: random and directed frames
module tb;
  import spi_rhc_pkg::*;

  localparam int CycleLimit = 200000;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  in_item_t   in_item = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_item_t  out_item;
  logic       cfg_wr_en = 1'b0;
  logic [9:0] cfg_wr_data = '0;

  in_item_t  item_q[$];
  out_item_t expected_q[$];
  int        errors = 0;
  int        cycles = 0;
  int        added = 0;
  int        stall_reqs = 0;
  int        stall_seen = 0;
  int        stall_left = 0;
  bit        calm = 1'b0;
  bit        in_taken = 1'b0;

  // frame tracker state
  logic [9:0]  win_cfg = SCAN_RESET;
  phase_t      fr_phase = PH_IDLE;
  logic [10:0] fr_pos = '0;
  hdr_idx_t    fr_hdr = HDR_NONE;
  logic        fr_dir = 1'b0;
  logic [15:0] fr_addr = '0;
  logic [15:0] fr_count = '0;
  logic [7:0]  fr_crc = '0;
  status_t     fr_code = ST_OK;
  logic [15:0] fr_left = '0;

  spi_response_header_checker dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_item    (out_item),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #1 clk = ~clk;

  function automatic logic [7:0] crc_next(input logic [7:0] acc, input logic [7:0] val);
    logic [7:0] r;
    r = acc;
    for (int i = 0; i < 8; i++) begin
      r = (r[0] ^ val[i]) ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

  task automatic track_byte(input in_item_t t);
    logic [7:0]  want;
    logic [7:0]  mark;
    logic [10:0] span;
    status_t     st;
    if (t.start_of_frame) begin
      fr_dir   = t.req_type;
      fr_addr  = t.expected_address;
      fr_count = t.expected_count;
      fr_phase = PH_SKIP;
      fr_pos   = '0;
      fr_hdr   = HDR_NONE;
      fr_crc   = '0;
      fr_code  = ST_OK;
      fr_left  = '0;
    end
    case (fr_phase)
      PH_SKIP: begin
        fr_pos = fr_pos + 11'd1;
        if (fr_pos >= SKIP_BYTES) begin
          fr_phase = PH_SCAN;
          fr_pos   = '0;
        end
      end
      PH_SCAN: begin
        mark = fr_dir ? WRITE_ACK : READ_ACK;
        span = (win_cfg == '0) ? 11'd1 : {1'b0, win_cfg};
        if (t.rx_byte == mark) begin
          fr_crc   = crc_next(8'h00, t.rx_byte);
          fr_hdr   = HDR_ADDR_LO;
          fr_code  = ST_OK;
          fr_phase = PH_HEADER;
        end else begin
          fr_pos = fr_pos + 11'd1;
          if (fr_pos >= span) begin
            fr_phase = PH_IDLE;
            expected_q.push_back('{has_data: 1'b0, data_byte: 8'h00, status: ST_NO_MARKER,
                                   last: 1'b1});
          end
        end
      end
      PH_HEADER: begin
        if (fr_hdr != HDR_CRC) begin
          case (fr_hdr)
            HDR_ADDR_LO:  want = fr_addr[7:0];
            HDR_ADDR_HI:  want = fr_addr[15:8];
            HDR_COUNT_LO: want = fr_count[7:0];
            default:      want = fr_count[15:8];
          endcase
          if (t.rx_byte != want && fr_code == ST_OK) begin
            fr_code = (fr_hdr == HDR_ADDR_LO || fr_hdr == HDR_ADDR_HI) ?
                      ST_ADDR_MISMATCH : ST_COUNT_MISMATCH;
          end
          fr_crc = crc_next(fr_crc, t.rx_byte);
          fr_hdr = hdr_idx_t'(fr_hdr + 3'd1);
        end else begin
          fr_hdr = HDR_NONE;
          st = fr_code;
          if (st == ST_OK && t.rx_byte != fr_crc) st = ST_CRC_ERROR;
          if (st != ST_OK || fr_dir || fr_count == '0) begin
            fr_phase = PH_IDLE;
            expected_q.push_back('{has_data: 1'b0, data_byte: 8'h00, status: st, last: 1'b1});
          end else begin
            fr_left  = fr_count;
            fr_phase = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        fr_left = fr_left - 16'd1;
        if (fr_left == '0) fr_phase = PH_IDLE;
        expected_q.push_back('{has_data: 1'b1, data_byte: t.rx_byte, status: ST_OK,
                               last: (fr_left == '0)});
      end
      default: fr_phase = PH_IDLE;
    endcase
  endtask

  always @(posedge clk) begin
    out_item_t want;
    cycles++;
    if (cycles == CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
    in_taken = in_valid && in_ready;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result: has_data %0d data_byte 0x%02h status %0d last %0d",
                 out_item.has_data, out_item.data_byte, out_item.status, out_item.last);
          errors++;
        end else begin
          want = expected_q.pop_front();
          if (out_item.has_data !== want.has_data) begin
            $error("has_data: expected %0d, got %0d", want.has_data, out_item.has_data);
            errors++;
          end
          if (out_item.data_byte !== want.data_byte) begin
            $error("data_byte: expected 0x%02h, got 0x%02h", want.data_byte, out_item.data_byte);
            errors++;
          end
          if (out_item.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_item.status);
            errors++;
          end
          if (out_item.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, out_item.last);
            errors++;
          end
        end
      end
      if (in_taken) track_byte(in_item);
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (item_q.size() != 0 && (calm || $urandom_range(0, 99) >= 12)) begin
        in_item  <= item_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (stall_left != 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (stall_seen != stall_reqs) begin
      stall_seen = stall_reqs;
      stall_left = 300;
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(0, 99) >= 12);
    end
  end

  function automatic in_item_t noise_item(input logic [7:0] b);
    in_item_t t;
    t.rx_byte          = b;
    t.start_of_frame   = 1'b0;
    t.req_type         = 1'($urandom_range(0, 1));
    t.expected_address = 16'($urandom);
    t.expected_count   = 16'($urandom);
    return t;
  endfunction

  task automatic put_byte(input logic [7:0] b);
    item_q.push_back(noise_item(b));
    added++;
  endtask

  // flip: addr lo, addr hi, count lo, count hi, crc; keep < 0 sends the whole frame
  task automatic put_frame(input logic dir, input logic [15:0] addr, input logic [15:0] cnt,
                           input int lead, input logic [4:0] flip, input int keep);
    in_item_t   f[$];
    in_item_t   t;
    logic [7:0] mark;
    logic [7:0] crc;
    logic [7:0] b;
    logic [7:0] hdr[4];
    int         pay;
    int         n;
    mark = dir ? WRITE_ACK : READ_ACK;
    t = noise_item(8'($urandom));
    t.start_of_frame   = 1'b1;
    t.req_type         = dir;
    t.expected_address = addr;
    t.expected_count   = cnt;
    f.push_back(t);
    repeat (SKIP_BYTES - 1) f.push_back(noise_item(8'($urandom)));
    repeat (lead) begin
      do b = 8'($urandom); while (b == mark);
      f.push_back(noise_item(b));
    end
    hdr[0] = addr[7:0];
    hdr[1] = addr[15:8];
    hdr[2] = cnt[7:0];
    hdr[3] = cnt[15:8];
    crc = crc_next(8'h00, mark);
    f.push_back(noise_item(mark));
    for (int i = 0; i < 4; i++) begin
      if (flip[i]) hdr[i] ^= 8'($urandom_range(1, 255));
      crc = crc_next(crc, hdr[i]);
      f.push_back(noise_item(hdr[i]));
    end
    if (flip[4]) crc ^= 8'($urandom_range(1, 255));
    f.push_back(noise_item(crc));
    pay = (!dir && flip == '0) ? int'(cnt) : 0;
    if (pay > 16) pay = $urandom_range(0, 12);
    repeat (pay) f.push_back(noise_item(8'($urandom)));
    n = (keep < 0 || keep > f.size()) ? f.size() : keep;
    for (int i = 0; i < n; i++) item_q.push_back(f[i]);
    added += n;
  endtask

  task automatic put_random_frames(input int span, input int goal);
    logic        dir;
    logic [15:0] cnt;
    logic [4:0]  flip;
    int          lead;
    int          keep;
    added = 0;
    while (added < goal) begin
      dir  = 1'($urandom_range(0, 1));
      cnt  = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6));
      flip = ($urandom_range(0, 3) == 0) ? 5'($urandom) : 5'd0;
      if ($urandom_range(0, 99) < 8 && span <= 40) lead = span;
      else lead = $urandom_range(0, (span > 4) ? 4 : span - 1);
      keep = ($urandom_range(0, 99) < 8) ? $urandom_range(1, 14) : -1;
      put_frame(dir, 16'($urandom), cnt, lead, flip, keep);
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 3)) put_byte(8'($urandom));
      end
    end
  endtask

  task automatic wait_drained();
    while (item_q.size() != 0 || in_valid || expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_window(input logic [9:0] w);
    wait_drained();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= w;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    win_cfg = w;
    @(posedge clk);
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset window: stray byte, good read, restart mid header, count mismatch with bad crc, address mismatch
    put_byte(READ_ACK);
    put_frame(1'b0, 16'hffff, 16'h0001, 0, 5'b00000, -1);
    put_frame(1'b1, 16'h0000, 16'hffff, 0, 5'b00000, 8);
    put_frame(1'b0, 16'h00ff, 16'h0000, 1, 5'b10100, -1);
    put_frame(1'b1, 16'hff00, 16'h00ff, 2, 5'b11011, -1);
    put_frame(1'b1, 16'($urandom), 16'($urandom), 20, 5'b00000, -1);
    put_random_frames(int'(SCAN_RESET), 70);

    set_window(10'd1);
    calm = 1'b1;
    put_frame(1'b0, 16'h1234, 16'h0003, 1, 5'b00000, -1);
    put_random_frames(1, 60);

    set_window(10'd0);
    calm = 1'b0;
    put_random_frames(1, 50);

    set_window(10'h3ff);
    put_frame(1'b0, 16'h5a5a, 16'h0002, 3, 5'b00000, -1);
    put_random_frames(1023, 60);

    set_window(10'($urandom_range(2, 40)));
    put_random_frames(int'(win_cfg), 45);
    @(posedge clk);
    stall_reqs++;
    wait_drained();
    put_random_frames(int'(win_cfg), 45);

    wait_drained();
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
